/* rtl/core/pgdp_pkg.sv */
// ----------------------------------------------------------------------------
// pgdp_pkg
// Shared types, register map and conversion tables for the grey dither packer.
// ----------------------------------------------------------------------------
package pgdp_pkg;

  typedef enum logic [0:0] {
    OP_PIXEL   = 1'b0,
    OP_PALETTE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FMT_PALETTE = 2'd0,
    FMT_RGB565  = 2'd1,
    FMT_BGR555  = 2'd2,
    FMT_BGR888  = 2'd3
  } fmt_t;

  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_FORMAT = 1'b0;
  localparam fmt_t FORMAT_RESET = FMT_BGR888;

  typedef logic [7:0] exp5_tbl_t [32];
  typedef logic [7:0] exp6_tbl_t [64];

  function automatic exp5_tbl_t build_exp5();
    exp5_tbl_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic exp6_tbl_t build_exp6();
    exp6_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam exp5_tbl_t EXP5 = build_exp5();
  localparam exp6_tbl_t EXP6 = build_exp6();

  // Bayer matrix, indexed by {row[1:0], column[1:0]}.
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  localparam logic [8:0] DITHER_OFFSET = 9'd30;

endpackage

/* rtl/core/pgdp_in_if.sv */
// ----------------------------------------------------------------------------
// pgdp_in_if
// Input channel: pixels to convert and palette entries to load.
// ----------------------------------------------------------------------------
interface pgdp_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  opcode;
  logic [7:0]  palette_slot;
  logic [23:0] entry_color;
  logic [23:0] pixel_value;
  logic [9:0]  column;
  logic [9:0]  line;

  modport source (
    output valid, opcode, palette_slot, entry_color, pixel_value, column, line,
    input  ready
  );
  modport sink (
    input  valid, opcode, palette_slot, entry_color, pixel_value, column, line,
    output ready
  );
endinterface

/* rtl/core/pgdp_out_if.sv */
// ----------------------------------------------------------------------------
// pgdp_out_if
// Output channel: packed bytes of four 2-bit grey codes.
// ----------------------------------------------------------------------------
interface pgdp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       line_end;

  modport source (
    output valid, packed_byte, line_end,
    input  ready
  );
  modport sink (
    input  valid, packed_byte, line_end,
    output ready
  );
endinterface

/* rtl/core/pixel_gray_dither_pack.sv */
// ----------------------------------------------------------------------------
// pixel_gray_dither_pack
// Converts pixels to grey, applies 4x4 ordered dither and packs 2-bit codes.
// ----------------------------------------------------------------------------
// Channel   Role    Carries
// pixels    sink    pixel or palette write items
// octets    source  packed byte and line end flag
// APB       slave   pixel_format register at byte address 0
//
// One item is taken every cycle while input ready is high. The palette memory
// read at the transfer feeds the dither stage behind it, which puts a byte in
// the output register when it holds the last pixel and the register is free.
// A palette write reaches the memory at its own transfer, so a pixel right
// behind it reads the new entry.
// A stalled output register holds its byte while the two stages behind it
// keep filling; input ready falls only when the output register is stalled,
// the dither stage holds a pixel that closes a byte and the read stage is full.
// Reset sets pixel_format to direct BGR and clears the pack accumulator.
// ----------------------------------------------------------------------------
module pixel_gray_dither_pack #(
  parameter int PALETTE_DEPTH = 256,
  parameter int LINE_WIDTH    = 800
) (
  input  logic                          clk,
  input  logic                          rst,
  pgdp_in_if.sink                       pixels,
  pgdp_out_if.source                    octets,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pgdp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pgdp_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [9:0] LAST_COL = 10'(LINE_WIDTH - 1);

  logic [23:0] palette [PALETTE_DEPTH];

  fmt_t        format;
  logic        cfg_write;

  logic        accept;
  logic        s1_valid;
  logic        s1_idx_ok;
  logic [23:0] s1_pixel;
  logic [23:0] s1_entry;
  logic [9:0]  s1_column;
  logic [1:0]  s1_row;
  logic        s1_advance;

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] gray_sum;

  logic        s2_valid;
  logic [7:0]  s2_gray;
  logic [1:0]  s2_pos;
  logic [1:0]  s2_row;
  logic        s2_last;
  logic        s2_emit;
  logic        s2_advance;

  logic [8:0]  biased;
  logic [8:0]  shifted;
  logic [1:0]  level;
  logic [1:0]  code;
  logic [7:0]  acc;
  logic [7:0]  acc_base;
  logic [7:0]  acc_next;
  logic [7:0]  code_bits;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_FORMAT);
  assign prdata    = (paddr[2] == REG_FORMAT) ? {30'd0, format} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      format <= FORMAT_RESET;
    end else if (cfg_write) begin
      format <= fmt_t'(pwdata[1:0]);
    end
  end

  assign out_free   = !out_valid || octets.ready;
  assign s2_emit    = (s2_pos == 2'd3) || s2_last;
  assign s2_advance = !s2_valid || !s2_emit || out_free;
  assign s1_advance = !s1_valid || s2_advance;
  assign pixels.ready = s1_advance;
  assign accept     = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pixels.opcode == OP_PALETTE) begin
        if (32'(pixels.palette_slot) < PALETTE_DEPTH) begin
          palette[pixels.palette_slot[IDX_W-1:0]] <= pixels.entry_color;
        end
      end else begin
        s1_entry <= palette[pixels.pixel_value[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= accept && (pixels.opcode == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixels.pixel_value;
      s1_idx_ok <= 32'(pixels.pixel_value) < PALETTE_DEPTH;
      s1_column <= pixels.column;
      s1_row    <= pixels.line[1:0];
    end
  end

  always_comb begin
    case (format)
      FMT_PALETTE: begin
        blue  = s1_idx_ok ? s1_entry[7:0]   : 8'd0;
        green = s1_idx_ok ? s1_entry[15:8]  : 8'd0;
        red   = s1_idx_ok ? s1_entry[23:16] : 8'd0;
      end
      FMT_RGB565: begin
        red   = EXP5[s1_pixel[15:11]];
        green = EXP6[s1_pixel[10:5]];
        blue  = EXP5[s1_pixel[4:0]];
      end
      FMT_BGR555: begin
        blue  = EXP5[s1_pixel[14:10]];
        green = EXP5[s1_pixel[9:5]];
        red   = EXP5[s1_pixel[4:0]];
      end
      default: begin
        blue  = s1_pixel[7:0];
        green = s1_pixel[15:8];
        red   = s1_pixel[23:16];
      end
    endcase
    gray_sum = 16'(16'(red) * 16'd77) + 16'(16'(green) * 16'd150)
             + 16'(16'(blue) * 16'd29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_advance && s1_valid) begin
      s2_gray <= gray_sum[15:8];
      s2_pos  <= s1_column[1:0];
      s2_row  <= s1_row;
      s2_last <= s1_column == LAST_COL;
    end
  end

  always_comb begin
    biased  = 9'(s2_gray) + {3'd0, BAYER[{s2_row, s2_pos}], 2'd0};
    shifted = biased - DITHER_OFFSET;
    if (biased < DITHER_OFFSET) begin
      level = 2'd0;
    end else if (shifted[8]) begin
      level = 2'd3;
    end else begin
      level = shifted[7:6];
    end
    code = ~level;
    acc_base = (s2_pos == 2'd0) ? 8'd0 : acc;
    case (s2_pos)
      2'd0:    code_bits = {code, 6'd0};
      2'd1:    code_bits = {2'd0, code, 4'd0};
      2'd2:    code_bits = {4'd0, code, 2'd0};
      default: code_bits = {6'd0, code};
    endcase
    acc_next = acc_base | code_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
    end else if (s2_valid && s2_advance) begin
      acc <= s2_emit ? 8'd0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid && s2_emit) begin
      out_byte <= acc_next;
      out_last <= s2_last;
    end
  end

  assign octets.valid       = out_valid;
  assign octets.packed_byte = out_byte;
  assign octets.line_end    = out_last;

endmodule

/* tb/pixel_gray_dither_pack_tb.sv */
// ----------------------------------------------------------------------------
// pixel_gray_dither_pack_tb
// Self-checking bench for the grey dither packer. A driver process feeds
// pixel and palette transfers from a queue that the stimulus block fills,
// phase by phase, in each pixel format. A second process predicts every
// packed byte with its own palette copy, dither table and pack accumulator.
// A monitor compares each output transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------
module pixel_gray_dither_pack_tb;
  import pgdp_pkg::*;

  localparam int PAL_DEPTH = 256;
  localparam int LINE_W = 800;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int DITHER_MATRIX [16] = '{
    0, 8, 2, 10,
    12, 4, 14, 6,
    3, 11, 1, 9,
    15, 7, 13, 5
  };
  localparam fmt_t PHASE_FMT [6] = '{
    FMT_BGR888, FMT_PALETTE, FMT_RGB565, FMT_BGR555, FMT_PALETTE, FMT_BGR888
  };

  typedef struct {
    op_t         opcode;
    logic [7:0]  palette_slot;
    logic [23:0] entry_color;
    logic [23:0] pixel_value;
    logic [9:0]  column;
    logic [9:0]  line;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       line_end;
  } packed_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pgdp_in_if pix_if ();
  pgdp_out_if oct_if ();

  pixel_gray_dither_pack #(
    .PALETTE_DEPTH(PAL_DEPTH),
    .LINE_WIDTH(LINE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_if),
    .octets(oct_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  stream_item_t stream_items [$];
  stream_item_t next_item;
  packed_out_t bytes_due [$];
  packed_out_t want;

  logic [23:0] palette_mem [PAL_DEPTH];
  logic [7:0] pack_acc = 8'h00;
  fmt_t cur_format = FORMAT_RESET;
  int slot_pos;
  logic at_line_end;

  fmt_t gen_fmt = FORMAT_RESET;
  bit [PAL_DEPTH-1:0] slot_written = '0;
  int gen_slots [$];

  bit in_taken = 1'b0;
  int send_idle_pct = 8;
  int recv_idle_pct = 50;
  int hold_cycles = 0;
  int items_queued = 0;
  int items_taken = 0;
  int writes_taken = 0;
  int bytes_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [1:0] pixel_code(logic [23:0] value, logic [9:0] col,
                                            logic [9:0] row);
    logic [23:0] rgb;
    logic [15:0] w;
    int r, g, b, gray, adj;
    w = value[15:0];
    rgb = value;
    if (cur_format == FMT_PALETTE) begin
      rgb = (value < PAL_DEPTH) ? palette_mem[value[7:0]] : 24'h000000;
    end
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    if (cur_format == FMT_RGB565) begin
      r = int'(w[15:11]) * 255 / 31;
      g = int'(w[10:5]) * 255 / 63;
      b = int'(w[4:0]) * 255 / 31;
    end else if (cur_format == FMT_BGR555) begin
      b = int'(w[14:10]) * 255 / 31;
      g = int'(w[9:5]) * 255 / 31;
      r = int'(w[4:0]) * 255 / 31;
    end
    gray = (77 * r + 150 * g + 29 * b) >> 8;
    adj = gray + 4 * DITHER_MATRIX[{row[1:0], col[1:0]}] - 30;
    if (adj < 0) adj = 0;
    if (adj > 255) adj = 255;
    return 2'(3 - (adj >> 6));
  endfunction

  // Input side: track the block's state at every accepted transfer.
  always @(posedge clk) begin
    if (!rst && pix_if.valid && pix_if.ready) begin
      in_taken = 1'b1;
      items_taken++;
      if (pix_if.opcode == OP_PALETTE) begin
        writes_taken++;
        if (int'(pix_if.palette_slot) < PAL_DEPTH) begin
          palette_mem[pix_if.palette_slot] = pix_if.entry_color;
        end
      end else begin
        slot_pos = int'(pix_if.column[1:0]);
        at_line_end = (int'(pix_if.column) == LINE_W - 1);
        if (slot_pos == 0) pack_acc = 8'h00;
        pack_acc = pack_acc |
          (8'(pixel_code(pix_if.pixel_value, pix_if.column, pix_if.line)) << (6 - 2 * slot_pos));
        if (slot_pos == 3 || at_line_end) begin
          bytes_due.push_back('{pack_acc, at_line_end});
          pack_acc = 8'h00;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || in_taken) begin
      if (stream_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = stream_items.pop_front();
        pix_if.valid <= 1'b1;
        pix_if.opcode <= next_item.opcode;
        pix_if.palette_slot <= next_item.palette_slot;
        pix_if.entry_color <= next_item.entry_color;
        pix_if.pixel_value <= next_item.pixel_value;
        pix_if.column <= next_item.column;
        pix_if.line <= next_item.line;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      oct_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      oct_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && oct_if.valid && oct_if.ready) begin
      bytes_seen++;
      if (bytes_due.size() == 0) begin
        $error("unexpected output transfer: packed_byte %02h line_end %0b",
               oct_if.packed_byte, oct_if.line_end);
        fail_count++;
      end else begin
        want = bytes_due.pop_front();
        if (want.packed_byte !== oct_if.packed_byte) begin
          $error("packed_byte: expected %02h, got %02h", want.packed_byte, oct_if.packed_byte);
          fail_count++;
        end
        if (want.line_end !== oct_if.line_end) begin
          $error("line_end: expected %0b, got %0b", want.line_end, oct_if.line_end);
          fail_count++;
        end
      end
    end
  end

  task automatic push_pixel(int col, int row, logic [23:0] value);
    stream_item_t it;
    it.opcode = OP_PIXEL;
    it.palette_slot = 8'($urandom);
    it.entry_color = 24'($urandom);
    it.pixel_value = value;
    it.column = 10'(col);
    it.line = 10'(row);
    stream_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_write(int slot, logic [23:0] color);
    stream_item_t it;
    it.opcode = OP_PALETTE;
    it.palette_slot = 8'(slot);
    it.entry_color = color;
    it.pixel_value = 24'($urandom);
    it.column = 10'($urandom);
    it.line = 10'($urandom);
    stream_items.push_back(it);
    items_queued++;
    if (slot < PAL_DEPTH && !slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      gen_slots.push_back(slot);
    end
  endtask

  // Palette indexes point at entries loaded earlier in the stream or past the palette end.
  function automatic logic [23:0] rand_value();
    if (gen_fmt != FMT_PALETTE) return 24'($urandom);
    if (gen_slots.size() != 0 && $urandom_range(99) < 85) begin
      return 24'(gen_slots[$urandom_range(gen_slots.size() - 1)]);
    end
    return 24'($urandom_range(24'hFFFFFF, PAL_DEPTH));
  endfunction

  task automatic gen_random(int n);
    int target, kind, groups, start, row;
    target = items_queued + n;
    while (items_queued < target) begin
      kind = $urandom_range(99);
      row = $urandom_range(1023);
      if (kind < 10) begin
        push_write($urandom_range(PAL_DEPTH - 1), 24'($urandom));
      end else if (kind < 85) begin
        groups = $urandom_range(4, 1);
        if ($urandom_range(99) < 20) start = LINE_W - 4 * groups;
        else start = 4 * $urandom_range(256 - groups);
        for (int c = 0; c < 4 * groups; c++) begin
          if ($urandom_range(99) < 5) push_write($urandom_range(PAL_DEPTH - 1), 24'($urandom));
          push_pixel(start + c, row, rand_value());
        end
      end else begin
        push_pixel($urandom_range(1023), row, rand_value());
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (items_taken != items_queued || bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_format(fmt_t f);
    logic [31:0] rd;
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_FORMAT);
    pwdata <= 32'(f);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    cur_format = f;
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd[1:0] !== f) begin
      $error("pixel_format readback: expected %0d, got %0d", f, rd[1:0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic next_phase(fmt_t f, int send_pct, int recv_pct);
    wait_idle();
    write_format(f);
    gen_fmt = f;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.opcode = OP_PIXEL;
    pix_if.palette_slot = '0;
    pix_if.entry_color = '0;
    pix_if.pixel_value = '0;
    pix_if.column = '0;
    pix_if.line = '0;
    oct_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Direct BGR from reset: a dropped partial group, then black and white extremes.
    push_pixel(0, 0, 24'h000000);
    push_pixel(1, 0, 24'hFFFFFF);
    push_pixel(0, 1, 24'hFFFFFF);
    push_pixel(1, 1, 24'h000000);
    push_pixel(2, 1, 24'h123456);
    push_pixel(3, 1, 24'hFF00FF);
    // Line end byte with a palette write in the middle of the group.
    push_pixel(LINE_W - 4, 1023, 24'h00FF00);
    push_write(255, 24'hFFFFFF);
    push_pixel(LINE_W - 3, 1023, 24'hFF0000);
    push_pixel(LINE_W - 2, 1023, 24'h0000FF);
    push_pixel(LINE_W - 1, 1023, 24'h808080);
    push_write(0, 24'h000000);

    // Palette lookup right behind its write, indexes out of range, columns past the line.
    next_phase(FMT_PALETTE, 8, 50);
    push_write(1, 24'h00FF00);
    push_pixel(1020, 2, 24'd1);
    push_pixel(1021, 2, 24'd255);
    push_pixel(1022, 2, 24'd256);
    push_pixel(1023, 2, 24'hFFFFFF);

    // Sixteen bit formats: extremes and the ignored upper bits.
    next_phase(FMT_RGB565, 8, 50);
    push_pixel(0, 3, 24'h00FFFF);
    push_pixel(1, 3, 24'h000000);
    push_pixel(2, 3, 24'hFF0000);
    push_pixel(3, 3, 24'h00F800);

    next_phase(FMT_BGR555, 8, 50);
    push_pixel(4, 2, 24'h007FFF);
    push_pixel(5, 2, 24'hFFFFFF);
    push_pixel(6, 2, 24'h008000);
    push_pixel(7, 2, 24'h00001F);

    for (int p = 0; p < 6; p++) begin
      if (p < 2) next_phase(PHASE_FMT[p], 8, 50);
      else if (p < 4) next_phase(PHASE_FMT[p], 50, 8);
      else next_phase(PHASE_FMT[p], 0, 0);
      gen_random(RANDOM_PER_PHASE);
      if (p == 1) hold_cycles = 60;
    end

    wait_idle();
    $display("Covered %0d input transfers (%0d palette writes) and %0d packed bytes",
             items_taken, writes_taken, bytes_seen);
    $display("over all four pixel formats, with stalls and idle gaps on both channels.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
